/* hdl/sap_pkg.sv */
// Package: payload structs, state codes and constants for the shelf atlas packer.
`default_nettype none
package sap_pkg;

  localparam int unsigned GLYPH_W  = 10;
  localparam int unsigned ROW_HW   = 11;
  localparam int unsigned DIV10_MUL = 205;
  localparam int unsigned DIV10_SH  = 11;
  localparam int unsigned MUL_W     = GLYPH_W + 8;

  localparam logic [1:0] STATUS_PLACED    = 2'd0;
  localparam logic [1:0] STATUS_ROWS_FULL = 2'd1;
  localparam logic [1:0] STATUS_TOO_BIG   = 2'd2;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_width;
    logic [GLYPH_W-1:0] glyph_height;
  } glyph_t;

  typedef struct packed {
    logic [11:0] place_x;
    logic [11:0] place_y;
    logic [12:0] atlas_size;
    logic        atlas_grew;
    logic [1:0]  status;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_GROW = 3'b100
  } state_t;

endpackage
`default_nettype wire

/* hdl/shelf_atlas_packer_top.sv */
// Top level: shelf row packer that places glyph rectangles into a square atlas.
// Each glyph scans the rows in order and lands on the first row that fits; if none fits it
// opens a new row, doubling the atlas as needed, or reports a full table or an oversize atlas.
// busy drops with done, so the next transfer is accepted at the edge that ends the strobe;
// a new glyph is taken only once the last one is done.
// Reset clears the row count, next top and atlas side; row memory needs no clearing pass.
`default_nettype none
module shelf_atlas_packer_top #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned INIT_ATLAS = 128,
  parameter int unsigned MAX_ATLAS  = 4096
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  input  wire sap_pkg::glyph_t glyph,
  output logic                 done,
  output sap_pkg::result_t     result
);

  localparam int unsigned SIDE_MAX = (MAX_ATLAS > INIT_ATLAS) ? MAX_ATLAS : INIT_ATLAS;
  localparam int unsigned SW  = $clog2(SIDE_MAX + 1);
  localparam int unsigned UMX = (SIDE_MAX > 1023) ? SIDE_MAX : 1023;
  localparam int unsigned UW  = $clog2(UMX + 1);
  localparam int unsigned AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned RHW = sap_pkg::ROW_HW;
  localparam int unsigned GW  = sap_pkg::GLYPH_W;

  typedef struct packed {
    logic [SW-1:0]  top;
    logic [RHW-1:0] height;
    logic [UW-1:0]  used;
  } row_t;

  row_t row_mem [MAX_ROWS];
  row_t rd_data;
  row_t wr_data;
  logic [AW-1:0] wr_addr;
  logic wr_en;

  sap_pkg::state_t state;
  logic [CW-1:0]  row_count;
  logic [SW-1:0]  next_row_top;
  logic [SW-1:0]  atlas_side;
  logic [SW-1:0]  work_side;
  logic           grew;
  logic [GW-1:0]  req_w;
  logic [GW-1:0]  req_h;
  logic [RHW-1:0] row_h;
  logic [CW-1:0]  scan_idx;
  logic [CW-1:0]  chk_idx;
  logic           chk_vld;

  logic [sap_pkg::MUL_W-1:0] h_mul;
  logic [RHW-1:0] new_rh;
  logic [13:0]    h_x10;
  logic [13:0]    r_x7;
  logic [UW:0]    used_sum;
  logic           hit;
  logic [SW:0]    bottom;
  logic           need_grow;

  assign h_mul  = sap_pkg::MUL_W'(glyph.glyph_height) * sap_pkg::MUL_W'(sap_pkg::DIV10_MUL);
  assign new_rh = RHW'(glyph.glyph_height) +
                  RHW'(h_mul[sap_pkg::MUL_W-1:sap_pkg::DIV10_SH]);

  assign h_x10    = {1'b0, req_h, 3'b000} + {3'b000, req_h, 1'b0};
  assign r_x7     = {rd_data.height, 3'b000} - {3'b000, rd_data.height};
  assign used_sum = (UW+1)'(rd_data.used) + (UW+1)'(req_w);
  assign hit = chk_vld && (RHW'(req_h) <= rd_data.height) && (h_x10 >= r_x7) &&
               ((UW+1)'(atlas_side) >= used_sum);

  assign bottom    = (SW+1)'(next_row_top) + (SW+1)'(row_h);
  assign need_grow = bottom >= (SW+1)'(work_side);

  assign busy = (state != sap_pkg::ST_IDLE);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_idx[AW-1:0];
    wr_data = rd_data;
    if (state == sap_pkg::ST_SCAN && hit) begin
      wr_en        = 1'b1;
      wr_data.used = UW'(used_sum);
    end else if (state == sap_pkg::ST_GROW && !need_grow) begin
      wr_en          = 1'b1;
      wr_addr        = row_count[AW-1:0];
      wr_data.top    = next_row_top;
      wr_data.height = row_h;
      wr_data.used   = UW'(req_w);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      row_mem[wr_addr] <= wr_data;
    end
    rd_data <= row_mem[scan_idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= sap_pkg::ST_IDLE;
      row_count    <= '0;
      next_row_top <= '0;
      atlas_side   <= SW'(INIT_ATLAS);
      done         <= 1'b0;
      chk_vld      <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        sap_pkg::ST_IDLE: begin
          if (start) begin
            req_w     <= glyph.glyph_width;
            req_h     <= glyph.glyph_height;
            row_h     <= new_rh;
            work_side <= atlas_side;
            grew      <= 1'b0;
            scan_idx  <= '0;
            chk_vld   <= 1'b0;
            state     <= sap_pkg::ST_SCAN;
          end
        end
        sap_pkg::ST_SCAN: begin
          if (hit) begin
            result.place_x    <= 12'(rd_data.used);
            result.place_y    <= 12'(rd_data.top);
            result.atlas_size <= 13'(atlas_side);
            result.atlas_grew <= 1'b0;
            result.status     <= sap_pkg::STATUS_PLACED;
            done              <= 1'b1;
            chk_vld           <= 1'b0;
            state             <= sap_pkg::ST_IDLE;
          end else if (scan_idx < row_count) begin
            chk_idx  <= scan_idx;
            chk_vld  <= 1'b1;
            scan_idx <= scan_idx + CW'(1);
          end else begin
            chk_vld <= 1'b0;
            if (row_count < CW'(MAX_ROWS)) begin
              state <= sap_pkg::ST_GROW;
            end else begin
              result.place_x    <= '0;
              result.place_y    <= '0;
              result.atlas_size <= 13'(atlas_side);
              result.atlas_grew <= 1'b0;
              result.status     <= sap_pkg::STATUS_ROWS_FULL;
              done              <= 1'b1;
              state             <= sap_pkg::ST_IDLE;
            end
          end
        end
        sap_pkg::ST_GROW: begin
          if (need_grow) begin
            if (work_side > SW'(MAX_ATLAS / 2)) begin
              result.place_x    <= '0;
              result.place_y    <= '0;
              result.atlas_size <= 13'(atlas_side);
              result.atlas_grew <= 1'b0;
              result.status     <= sap_pkg::STATUS_TOO_BIG;
              done              <= 1'b1;
              state             <= sap_pkg::ST_IDLE;
            end else begin
              work_side <= {work_side[SW-2:0], 1'b0};
              grew      <= 1'b1;
            end
          end else begin
            row_count         <= row_count + CW'(1);
            next_row_top      <= SW'(bottom);
            atlas_side        <= work_side;
            result.place_x    <= '0;
            result.place_y    <= 12'(next_row_top);
            result.atlas_size <= 13'(work_side);
            result.atlas_grew <= grew;
            result.status     <= sap_pkg::STATUS_PLACED;
            done              <= 1'b1;
            state             <= sap_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= sap_pkg::ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
